>>> rtl/cma_pkg.sv
// ============================================================================
// cma_pkg
// shared types, constants and the month length table for the minute advance unit
// ============================================================================
package cma_pkg;

    localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [4:0]  HOUR_MAX        = 5'd23;
    localparam logic [5:0]  MINUTE_MAX      = 6'd59;
    localparam logic [4:0]  DAY_RESET       = 5'd1;
    localparam logic [3:0]  MONTH_RESET     = 4'd1;
    localparam logic [15:0] YEAR_RESET      = 16'd1400;
    localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
    // reciprocal of 60 scaled by 2^16, exact for values below 1440
    localparam logic [10:0] RECIP_60        = 11'd1093;
    localparam int unsigned TOTAL_W         = 17;

    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_LOAD    = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic capture;   // latch an accepted transaction
        logic run;       // one day carry or final minute commit
        logic emit;      // load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;   // captured transaction was a load
        logic day_left;  // running total still holds a whole day
    } dp_status_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] minutes_to_add;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
    } item_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [15:0] out_year;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
    } result_t;

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [15:0] year);
        logic [4:0] len;
        begin
            unique case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
                default: len = 5'd30;
            endcase
            return len;
        end
    endfunction

endpackage

>>> rtl/cma_item_if.sv
// ============================================================================
// cma_item_if
// input channel: one advance or load transaction
// ============================================================================
interface cma_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] minutes_to_add;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;

    modport source (output valid, cmd, minutes_to_add, load_day, load_month,
                    load_year, load_hour, load_minute, input ready);
    modport sink   (input valid, cmd, minutes_to_add, load_day, load_month,
                    load_year, load_hour, load_minute, output ready);
endinterface

>>> rtl/cma_result_if.sv
// ============================================================================
// cma_result_if
// output channel: date and time after each transaction
// ============================================================================
interface cma_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;

    modport source (output valid, out_day, out_month, out_year, out_hour,
                    out_minute, input ready);
    modport sink   (input valid, out_day, out_month, out_year, out_hour,
                    out_minute, output ready);
endinterface

>>> rtl/cma_ctrl.sv
// ============================================================================
// cma_ctrl
// sequencer: accept, carry days one per cycle, hand result to output register
// ============================================================================
module cma_ctrl
    import cma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    output dp_cmd_t    dp_cmd,
    input  dp_status_t dp_status
);

    ctrl_state_t state_reg, state_next;
    logic        rvalid_reg, rvalid_next;
    logic        out_free;

    assign out_free     = !rvalid_reg || result_ready;
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = rvalid_reg;

    always_comb
    begin
        state_next     = state_reg;
        dp_cmd.capture = 1'b0;
        dp_cmd.run     = 1'b0;
        dp_cmd.emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // a load has nothing to carry
                if (dp_status.is_load)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    dp_cmd.run = 1'b1;
                    if (!dp_status.day_left)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    dp_cmd.emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (dp_cmd.emit)
        begin
            rvalid_next = 1'b1;
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

endmodule

>>> rtl/cma_dp.sv
// ============================================================================
// cma_dp
// datapath: calendar state, running minute total, day carry, result register
// ============================================================================
module cma_dp
    import cma_pkg::*;
#(
    parameter int unsigned MAX_ADVANCE_MINUTES = 43200
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    dp_cmd,
    output dp_status_t dp_status,
    input  item_t      item,
    output result_t    result
);

    localparam logic [19:0] MAX_ADV = 20'(MAX_ADVANCE_MINUTES);

    logic [10:0]        mod_reg, mod_next;
    logic [4:0]         day_reg, day_next;
    logic [3:0]         month_reg, month_next;
    logic [15:0]        year_reg, year_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               load_reg, load_next;
    result_t            result_reg, result_next;

    logic [15:0] add_sat;
    logic [4:0]  hour_sat;
    logic [5:0]  min_sat;
    logic        day_left;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic [21:0] hour_prod;
    logic [4:0]  hour_val;
    logic [10:0] hour_mins;

    assign add_sat  = ({4'b0, item.minutes_to_add} > MAX_ADV) ? MAX_ADV[15:0]
                                                              : item.minutes_to_add;
    assign hour_sat = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
    assign min_sat  = (item.load_minute > MINUTE_MAX) ? MINUTE_MAX : item.load_minute;

    assign day_left  = (total_reg >= TOTAL_W'(MINUTES_PER_DAY));
    assign day_inc   = {1'b0, day_reg} + 6'd1;
    assign month_inc = {1'b0, month_reg} + 5'd1;

    // hour = minute_of_day / 60 by reciprocal, minute by back-multiply
    assign hour_prod = mod_reg * RECIP_60;
    assign hour_val  = hour_prod[20:16];
    assign hour_mins = ({6'b0, hour_val} << 6) - ({6'b0, hour_val} << 2);

    assign dp_status.is_load  = load_reg;
    assign dp_status.day_left = day_left;
    assign result             = result_reg;

    always_comb
    begin
        mod_next    = mod_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        total_next  = total_reg;
        load_next   = load_reg;
        result_next = result_reg;

        if (dp_cmd.capture)
        begin
            load_next = (item.cmd == CMD_LOAD);
            if (item.cmd == CMD_LOAD)
            begin
                day_next   = item.load_day;
                month_next = item.load_month;
                year_next  = item.load_year;
                mod_next   = 11'(({6'b0, hour_sat} << 6) - ({6'b0, hour_sat} << 2))
                             + {5'b0, min_sat};
            end
            else
            begin
                total_next = TOTAL_W'(mod_reg) + TOTAL_W'(add_sat);
            end
        end

        if (dp_cmd.run)
        begin
            if (day_left)
            begin
                total_next = total_reg - TOTAL_W'(MINUTES_PER_DAY);
                if (day_inc > {1'b0, month_length(month_reg, year_reg)})
                begin
                    day_next = 5'd1;
                    if (month_inc > MONTHS_PER_YEAR)
                    begin
                        month_next = 4'd1;
                        year_next  = year_reg + 16'd1;
                    end
                    else
                    begin
                        month_next = month_inc[3:0];
                    end
                end
                else
                begin
                    day_next = day_inc[4:0];
                end
            end
            else
            begin
                mod_next = total_reg[10:0];
            end
        end

        if (dp_cmd.emit)
        begin
            result_next.out_day    = day_reg;
            result_next.out_month  = month_reg;
            result_next.out_year   = year_reg;
            result_next.out_hour   = hour_val;
            result_next.out_minute = 6'(mod_reg - hour_mins);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= '0;
            day_reg   <= DAY_RESET;
            month_reg <= MONTH_RESET;
            year_reg  <= YEAR_RESET;
            load_reg  <= 1'b0;
        end
        else
        begin
            mod_reg   <= mod_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            load_reg  <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg  <= total_next;
        result_reg <= result_next;
    end

endmodule

>>> rtl/calendar_minute_advance_unit.sv
// ============================================================================
// calendar_minute_advance_unit
// julian calendar clock: advance by minutes or load a date and time
// ============================================================================
//
//  channel  | dir  | transaction payload
//  ---------+------+--------------------------------------------------------
//  item     | in   | cmd, minutes_to_add, load_day/month/year/hour/minute
//  result   | out  | out_day, out_month, out_year, out_hour, out_minute
//
//  a load passes through the idle, run and finish states; an advance stays in
//  run while it carries whole days (one day per cycle in the carry loop)
//  a result waits in the output register while the next transaction runs;
//  it stalls only in its finish state if the previous result is still unread
//  reset: time 00:00, day 1, month 1, year 1400; no results pending
//
module calendar_minute_advance_unit
    import cma_pkg::*;
#(
    parameter int unsigned MAX_ADVANCE_MINUTES = 43200
)
(
    input  logic         clk,
    input  logic         rst_n,
    cma_item_if.sink     item,
    cma_result_if.source result
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    item_t      item_data;
    result_t    result_data;

    // gather the transaction fields for the datapath
    assign item_data.cmd            = item.cmd;
    assign item_data.minutes_to_add = item.minutes_to_add;
    assign item_data.load_day       = item.load_day;
    assign item_data.load_month     = item.load_month;
    assign item_data.load_year      = item.load_year;
    assign item_data.load_hour      = item.load_hour;
    assign item_data.load_minute    = item.load_minute;

    // sequencer: one-hot fsm plus result valid flag
    cma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status)
    );

    // calendar state, carry loop and result register
    cma_dp #(
        .MAX_ADVANCE_MINUTES (MAX_ADVANCE_MINUTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .item      (item_data),
        .result    (result_data)
    );

    assign result.out_day    = result_data.out_day;
    assign result.out_month  = result_data.out_month;
    assign result.out_year   = result_data.out_year;
    assign result.out_hour   = result_data.out_hour;
    assign result.out_minute = result_data.out_minute;

endmodule
